// ----- src/fdsm_pkg.sv -----
`default_nettype none
package fdsm_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 512;

  // wide enough for a position + 1 against a clamped size at the largest frame limit
  localparam int POS_CMP_W = 13;

  localparam int PIX_W   = 8;
  localparam int FW_W    = 11;
  localparam int FH_W    = 10;
  localparam int THR_W   = 8;
  localparam int PITCH_W = 8;
  localparam int SROW_W  = 9;
  localparam int SCOL_W  = 10;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_DIFF_THRESHOLD = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPOT_PITCH     = CFG_IDX_W'(3);

  localparam logic [FW_W-1:0]    RST_FRAME_WIDTH    = FW_W'(640);
  localparam logic [FH_W-1:0]    RST_FRAME_HEIGHT   = FH_W'(480);
  localparam logic [THR_W-1:0]   RST_DIFF_THRESHOLD = THR_W'(20);
  localparam logic [PITCH_W-1:0] RST_SPOT_PITCH     = PITCH_W'(31);

  // bgr to gray, 14-bit fixed point
  localparam int W_BLUE     = 1868;
  localparam int W_GREEN    = 9617;
  localparam int W_RED      = 4899;
  localparam int GRAY_SHIFT = 14;
  localparam int GRAY_ROUND = 8192;
  localparam int PROD_W     = 22;
  localparam int SUM_W      = 23;

  localparam int OUT_FIFO_DEPTH = 4;

  typedef struct packed {
    logic [FW_W-1:0]    frame_width;
    logic [FH_W-1:0]    frame_height;
    logic [THR_W-1:0]   diff_threshold;
    logic [PITCH_W-1:0] spot_pitch;
  } cfg_t;

  typedef struct packed {
    logic              is_spot;
    logic [SROW_W-1:0] spot_row;
    logic [SCOL_W-1:0] spot_col;
    logic              end_of_frame;
  } tag_t;

  typedef struct packed {
    logic [PIX_W-1:0]  gray;
    logic              foreground;
    logic              is_spot;
    logic              spot_motion;
    logic [SROW_W-1:0] spot_row;
    logic [SCOL_W-1:0] spot_col;
    logic              end_of_frame;
  } res_t;

endpackage
`default_nettype wire

// ----- src/fdsm_if.sv -----
`default_nettype none
interface fdsm_pix_if;
  logic                         valid;
  logic                         ready;
  logic [fdsm_pkg::PIX_W-1:0]   blue;
  logic [fdsm_pkg::PIX_W-1:0]   green;
  logic [fdsm_pkg::PIX_W-1:0]   red;
  logic                         frame_start;
  modport source (output valid, output blue, output green, output red, output frame_start,
                  input ready);
  modport sink (input valid, input blue, input green, input red, input frame_start,
                output ready);
endinterface

interface fdsm_res_if;
  logic                         valid;
  logic                         ready;
  logic [fdsm_pkg::PIX_W-1:0]   gray;
  logic                         foreground;
  logic                         is_spot;
  logic                         spot_motion;
  logic [fdsm_pkg::SROW_W-1:0]  spot_row;
  logic [fdsm_pkg::SCOL_W-1:0]  spot_col;
  logic                         end_of_frame;
  modport source (output valid, output gray, output foreground, output is_spot,
                  output spot_motion, output spot_row, output spot_col, output end_of_frame,
                  input ready);
  modport sink (input valid, input gray, input foreground, input is_spot,
                input spot_motion, input spot_row, input spot_col, input end_of_frame,
                output ready);
endinterface

interface fdsm_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [fdsm_pkg::CFG_IDX_W-1:0]   index;
  logic [fdsm_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- src/fdsm_raster.sv -----
`default_nettype none
module fdsm_raster #(
  parameter int MAX_WIDTH  = fdsm_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = fdsm_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst,
  input  wire logic                                        step,
  input  wire logic                                        frame_start,
  input  wire fdsm_pkg::cfg_t                              cfg,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]          addr,
  output fdsm_pkg::tag_t                                   tag
);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int AW = $clog2(MAX_WIDTH*MAX_HEIGHT);
  localparam int PW = fdsm_pkg::PITCH_W;
  localparam int XW = fdsm_pkg::POS_CMP_W;

  logic [CW-1:0] col, col_next, cur_col;
  logic [RW-1:0] row, row_next, cur_row;
  logic [AW-1:0] row_base, row_base_next, cur_base;
  logic [PW-1:0] col_phase, col_phase_next, cur_cph;
  logic [PW-1:0] row_phase, row_phase_next, cur_rph;
  logic [CW-1:0] spot_col_idx, spot_col_idx_next, cur_sci;
  logic [RW-1:0] spot_row_idx, spot_row_idx_next, cur_sri;

  logic [XW-1:0] fw, fh, w_eff, h_eff;
  logic [PW:0]   p_eff;
  logic          last_col, last_row, col_wrap, row_wrap, spot;

  always_comb begin
    cur_col  = frame_start ? '0 : col;
    cur_row  = frame_start ? '0 : row;
    cur_base = frame_start ? '0 : row_base;
    cur_cph  = frame_start ? '0 : col_phase;
    cur_rph  = frame_start ? '0 : row_phase;
    cur_sci  = frame_start ? '0 : spot_col_idx;
    cur_sri  = frame_start ? '0 : spot_row_idx;

    fw = XW'(cfg.frame_width);
    fh = XW'(cfg.frame_height);
    if (fw == '0) begin
      w_eff = XW'(1);
    end else if (fw > XW'(MAX_WIDTH)) begin
      w_eff = XW'(MAX_WIDTH);
    end else begin
      w_eff = fw;
    end
    if (fh == '0) begin
      h_eff = XW'(1);
    end else if (fh > XW'(MAX_HEIGHT)) begin
      h_eff = XW'(MAX_HEIGHT);
    end else begin
      h_eff = fh;
    end
    p_eff = (cfg.spot_pitch == '0) ? (PW+1)'(1) : {1'b0, cfg.spot_pitch};

    last_col = (XW'(cur_col) + XW'(1)) >= w_eff;
    last_row = (XW'(cur_row) + XW'(1)) >= h_eff;
    col_wrap = ({1'b0, cur_cph} + (PW+1)'(1)) >= p_eff;
    row_wrap = ({1'b0, cur_rph} + (PW+1)'(1)) >= p_eff;
    spot     = (cur_cph == '0) && (cur_rph == '0);

    addr             = cur_base + AW'(cur_col);
    tag.is_spot      = spot;
    tag.spot_row     = spot ? fdsm_pkg::SROW_W'(cur_sri) : '0;
    tag.spot_col     = spot ? fdsm_pkg::SCOL_W'(cur_sci) : '0;
    tag.end_of_frame = last_col && last_row;

    col_next          = '0;
    row_next          = '0;
    row_base_next     = '0;
    col_phase_next    = '0;
    row_phase_next    = '0;
    spot_col_idx_next = '0;
    spot_row_idx_next = '0;
    if (!last_col) begin
      col_next          = cur_col + CW'(1);
      col_phase_next    = col_wrap ? '0 : cur_cph + PW'(1);
      spot_col_idx_next = cur_sci + CW'(col_wrap);
      row_next          = cur_row;
      row_base_next     = cur_base;
      row_phase_next    = cur_rph;
      spot_row_idx_next = cur_sri;
    end else if (!last_row) begin
      row_next          = cur_row + RW'(1);
      row_base_next     = cur_base + AW'(MAX_WIDTH);
      row_phase_next    = row_wrap ? '0 : cur_rph + PW'(1);
      spot_row_idx_next = cur_sri + RW'(row_wrap);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col          <= '0;
      row          <= '0;
      row_base     <= '0;
      col_phase    <= '0;
      row_phase    <= '0;
      spot_col_idx <= '0;
      spot_row_idx <= '0;
    end else if (step) begin
      col          <= col_next;
      row          <= row_next;
      row_base     <= row_base_next;
      col_phase    <= col_phase_next;
      row_phase    <= row_phase_next;
      spot_col_idx <= spot_col_idx_next;
      spot_row_idx <= spot_row_idx_next;
    end
  end
endmodule
`default_nettype wire

// ----- src/fdsm_frame_store.sv -----
`default_nettype none
module fdsm_frame_store #(
  parameter int DEPTH = fdsm_pkg::MAX_WIDTH_DEF * fdsm_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]         rd_addr,
  output logic [fdsm_pkg::PIX_W-1:0]            rd_data,
  input  wire logic                             wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]         wr_addr,
  input  wire logic [fdsm_pkg::PIX_W-1:0]       wr_data,
  output logic                                  clearing
);
  localparam int AW = $clog2(DEPTH);
  localparam int DW = fdsm_pkg::PIX_W;

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] ram_q;
  logic [DW-1:0] fwd_data;
  logic          fwd_hit;
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      ram_q <= mem[rd_addr];
    end
    // a write landing on the entry being read in the same cycle
    fwd_data <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (rd_en) begin
      fwd_hit <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + AW'(1);
    end
  end

  assign rd_data = fwd_hit ? fwd_data : ram_q;
endmodule
`default_nettype wire

// ----- src/fdsm_out_fifo.sv -----
`default_nettype none
module fdsm_out_fifo #(
  parameter int DEPTH = fdsm_pkg::OUT_FIFO_DEPTH
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  input  wire fdsm_pkg::res_t              push_data,
  input  wire logic                        pop,
  output logic                             head_valid,
  output fdsm_pkg::res_t                   head,
  output logic [$clog2(DEPTH+1)-1:0]       count
);
  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH+1);

  fdsm_pkg::res_t slots [DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      count <= count + NW'(push) - NW'(pop);
    end
  end

  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
endmodule
`default_nettype wire

// ----- src/frame_difference_spot_motion.sv -----
`default_nettype none
// channel  dir  handshake      payload
// pix      in   valid/ready    blue, green, red, frame_start
// res      out  valid/ready    gray, foreground, is_spot, spot_motion, spot_row, spot_col,
//                              end_of_frame
// cfg      in   valid/ready    index, data (ready always high)
//
// one pixel per clock sustained while the output keeps up; a result passes from the
// frame store read through the gray/difference stage into a four-entry output queue
// after reset the frame store is zeroed, all MAX_WIDTH*MAX_HEIGHT entries (524288 by default),
// with pix.ready low; configuration writes are taken meanwhile
// a stalled output fills the queue and then drops pix.ready; nothing is lost
module frame_difference_spot_motion #(
  parameter int MAX_WIDTH  = fdsm_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = fdsm_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  fdsm_pix_if.sink    pix,
  fdsm_res_if.source  res,
  fdsm_cfg_if.sink    cfg
);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int QD    = fdsm_pkg::OUT_FIFO_DEPTH;
  localparam int NW    = $clog2(QD + 1);
  localparam int PRW   = fdsm_pkg::PROD_W;
  localparam int SW    = fdsm_pkg::SUM_W;
  localparam int GW    = fdsm_pkg::PIX_W;
  localparam int HW    = SW - fdsm_pkg::GRAY_SHIFT;

  fdsm_pkg::cfg_t cfg_regs;
  logic           accept;
  logic           clearing;
  logic [AW-1:0]  rd_addr;
  fdsm_pkg::tag_t s0_tag;

  logic           s1_valid;
  logic [AW-1:0]  s1_addr;
  fdsm_pkg::tag_t s1_tag;
  logic [PRW-1:0] s1_pb, s1_pg, s1_pr;
  logic [GW-1:0]  prev_gray;

  logic [SW-1:0]              sum;
  logic [HW-1:0]              shifted;
  logic [GW-1:0]              gray, diff;
  logic                       fg;
  fdsm_pkg::res_t             s1_res, head;
  logic                       head_valid;
  logic [NW-1:0]              q_count;
  logic [NW:0]                in_flight;

  // configuration registers
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.frame_width    <= fdsm_pkg::RST_FRAME_WIDTH;
      cfg_regs.frame_height   <= fdsm_pkg::RST_FRAME_HEIGHT;
      cfg_regs.diff_threshold <= fdsm_pkg::RST_DIFF_THRESHOLD;
      cfg_regs.spot_pitch     <= fdsm_pkg::RST_SPOT_PITCH;
    end else if (cfg.valid) begin
      case (cfg.index)
        fdsm_pkg::REG_FRAME_WIDTH:
          cfg_regs.frame_width <= cfg.data[fdsm_pkg::FW_W-1:0];
        fdsm_pkg::REG_FRAME_HEIGHT:
          cfg_regs.frame_height <= cfg.data[fdsm_pkg::FH_W-1:0];
        fdsm_pkg::REG_DIFF_THRESHOLD:
          cfg_regs.diff_threshold <= cfg.data[fdsm_pkg::THR_W-1:0];
        fdsm_pkg::REG_SPOT_PITCH:
          cfg_regs.spot_pitch <= cfg.data[fdsm_pkg::PITCH_W-1:0];
        default: ;
      endcase
    end
  end

  // room for the pixel in stage 1 plus everything queued
  assign in_flight = (NW+1)'(q_count) + (NW+1)'(s1_valid);
  assign pix.ready = !clearing && (in_flight < (NW+1)'(QD));
  assign accept    = pix.valid && pix.ready;

  fdsm_raster #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_raster (
    .clk         (clk),
    .rst         (rst),
    .step        (accept),
    .frame_start (pix.frame_start),
    .cfg         (cfg_regs),
    .addr        (rd_addr),
    .tag         (s0_tag)
  );

  fdsm_frame_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept),
    .rd_addr  (rd_addr),
    .rd_data  (prev_gray),
    .wr_en    (s1_valid),
    .wr_addr  (s1_addr),
    .wr_data  (gray),
    .clearing (clearing)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr <= rd_addr;
      s1_tag  <= s0_tag;
      s1_pb   <= PRW'(pix.blue) * PRW'(fdsm_pkg::W_BLUE);
      s1_pg   <= PRW'(pix.green) * PRW'(fdsm_pkg::W_GREEN);
      s1_pr   <= PRW'(pix.red) * PRW'(fdsm_pkg::W_RED);
    end
  end

  always_comb begin
    sum     = SW'(s1_pb) + SW'(s1_pg) + SW'(s1_pr) + SW'(fdsm_pkg::GRAY_ROUND);
    shifted = sum[SW-1:fdsm_pkg::GRAY_SHIFT];
    gray    = (shifted > HW'(255)) ? {GW{1'b1}} : shifted[GW-1:0];
    diff    = (gray >= prev_gray) ? gray - prev_gray : prev_gray - gray;
    fg      = diff > cfg_regs.diff_threshold;

    s1_res.gray         = gray;
    s1_res.foreground   = fg;
    s1_res.is_spot      = s1_tag.is_spot;
    s1_res.spot_motion  = s1_tag.is_spot && fg;
    s1_res.spot_row     = s1_tag.spot_row;
    s1_res.spot_col     = s1_tag.spot_col;
    s1_res.end_of_frame = s1_tag.end_of_frame;
  end

  fdsm_out_fifo #(
    .DEPTH (QD)
  ) u_out (
    .clk        (clk),
    .rst        (rst),
    .push       (s1_valid),
    .push_data  (s1_res),
    .pop        (res.valid && res.ready),
    .head_valid (head_valid),
    .head       (head),
    .count      (q_count)
  );

  assign res.valid        = head_valid;
  assign res.gray         = head.gray;
  assign res.foreground   = head.foreground;
  assign res.is_spot      = head.is_spot;
  assign res.spot_motion  = head.spot_motion;
  assign res.spot_row     = head.spot_row;
  assign res.spot_col     = head.spot_col;
  assign res.end_of_frame = head.end_of_frame;

`ifndef ASSERT_OFF
  a_no_pixel_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !pix.ready)
    else $error("pixel channel open during frame store clear");

  a_queue_never_overflows: assert property (@(posedge clk) disable iff (rst)
    in_flight <= (NW+1)'(QD))
    else $error("more results in flight than the output queue holds");

  a_result_follows_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid && (s1_addr == $past(rd_addr)))
    else $error("stage 1 lost an accepted pixel");

  a_no_result_before_clear_done: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !res.valid && !s1_valid)
    else $error("result produced before frame store clear finished");
`endif
endmodule
`default_nettype wire

// ----- sim/frame_difference_spot_motion_test.sv -----
`timescale 1ns / 100ps
module frame_difference_spot_motion_test;

  localparam int STORE_DEPTH   = fdsm_pkg::MAX_WIDTH_DEF * fdsm_pkg::MAX_HEIGHT_DEF;
  localparam int RUN_LIMIT     = 2_000_000;
  localparam int SETTLE_CYCLES = 16;

  // no register lives here; bits 2 and 3 of the index get exercised too
  localparam logic [fdsm_pkg::CFG_IDX_W-1:0] REG_UNUSED = fdsm_pkg::CFG_IDX_W'(13);

  // bgr to gray weights, 14-bit fixed point
  localparam int unsigned LUMA_B    = 1868;
  localparam int unsigned LUMA_G    = 9617;
  localparam int unsigned LUMA_R    = 4899;
  localparam int unsigned LUMA_HALF = 8192;

  logic clk = 1'b0;
  logic rst;

  always #4 clk = ~clk;

  fdsm_pix_if pix ();
  fdsm_res_if res ();
  fdsm_cfg_if cfg ();

  frame_difference_spot_motion dut (
    .clk (clk),
    .rst (rst),
    .pix (pix),
    .res (res),
    .cfg (cfg)
  );

  // predictor copy of configuration and raster state
  logic [fdsm_pkg::FW_W-1:0]    width_reg;
  logic [fdsm_pkg::FH_W-1:0]    height_reg;
  logic [fdsm_pkg::THR_W-1:0]   thresh_reg;
  logic [fdsm_pkg::PITCH_W-1:0] pitch_reg;
  logic [fdsm_pkg::PIX_W-1:0]   prior_luma [STORE_DEPTH];
  int unsigned                  col_pos, row_pos, col_phase, row_phase, grid_col, grid_row;

  fdsm_pkg::res_t pending_motion [$];
  int             error_count = 0;
  int unsigned    cycle_count = 0;
  int unsigned    sink_stall = 0;
  bit             src_idle_on;
  bit             sink_idle_on;

  function automatic int unsigned clamp_to(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [fdsm_pkg::PIX_W-1:0] sat8(int unsigned v);
    return (v > 255) ? 8'hFF : fdsm_pkg::PIX_W'(v);
  endfunction

  function void home_position();
    col_pos = 0;
    row_pos = 0;
    col_phase = 0;
    row_phase = 0;
    grid_col = 0;
    grid_row = 0;
  endfunction

  function automatic fdsm_pkg::res_t predict_motion(logic [fdsm_pkg::PIX_W-1:0] b,
                                                    logic [fdsm_pkg::PIX_W-1:0] g,
                                                    logic [fdsm_pkg::PIX_W-1:0] r,
                                                    logic fs);
    int unsigned    w, h, p, luma, prev, diff, addr;
    bit             spot, last_col, last_row;
    fdsm_pkg::res_t o;
    w = clamp_to(width_reg, fdsm_pkg::MAX_WIDTH_DEF);
    h = clamp_to(height_reg, fdsm_pkg::MAX_HEIGHT_DEF);
    p = clamp_to(pitch_reg, 255);
    if (fs) home_position();
    luma = (LUMA_B * b + LUMA_G * g + LUMA_R * r + LUMA_HALF) >> 14;
    if (luma > 255) luma = 255;
    addr = row_pos * fdsm_pkg::MAX_WIDTH_DEF + col_pos;
    if (addr >= STORE_DEPTH) addr = 0;
    prev = prior_luma[addr];
    prior_luma[addr] = fdsm_pkg::PIX_W'(luma);
    diff = (luma >= prev) ? luma - prev : prev - luma;
    spot = (col_phase == 0) && (row_phase == 0);
    last_col = col_pos + 1 >= w;
    last_row = row_pos + 1 >= h;
    o.gray = fdsm_pkg::PIX_W'(luma);
    o.foreground = diff > thresh_reg;
    o.is_spot = spot;
    o.spot_motion = spot && (diff > thresh_reg);
    o.spot_row = spot ? fdsm_pkg::SROW_W'(grid_row) : '0;
    o.spot_col = spot ? fdsm_pkg::SCOL_W'(grid_col) : '0;
    o.end_of_frame = last_col && last_row;
    if (!last_col) begin
      col_pos++;
      if (col_phase + 1 >= p) begin
        col_phase = 0;
        grid_col++;
      end else begin
        col_phase++;
      end
    end else if (!last_row) begin
      col_pos = 0;
      col_phase = 0;
      grid_col = 0;
      row_pos++;
      if (row_phase + 1 >= p) begin
        row_phase = 0;
        grid_row++;
      end else begin
        row_phase++;
      end
    end else begin
      home_position();
    end
    return o;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : scoreboard
    fdsm_pkg::res_t want;
    int             slot;
    if (rst) begin
      width_reg = fdsm_pkg::RST_FRAME_WIDTH;
      height_reg = fdsm_pkg::RST_FRAME_HEIGHT;
      thresh_reg = fdsm_pkg::RST_DIFF_THRESHOLD;
      pitch_reg = fdsm_pkg::RST_SPOT_PITCH;
      home_position();
      for (slot = 0; slot < STORE_DEPTH; slot++) prior_luma[slot] = '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          fdsm_pkg::REG_FRAME_WIDTH:    width_reg = cfg.data[fdsm_pkg::FW_W-1:0];
          fdsm_pkg::REG_FRAME_HEIGHT:   height_reg = cfg.data[fdsm_pkg::FH_W-1:0];
          fdsm_pkg::REG_DIFF_THRESHOLD: thresh_reg = cfg.data[fdsm_pkg::THR_W-1:0];
          fdsm_pkg::REG_SPOT_PITCH:     pitch_reg = cfg.data[fdsm_pkg::PITCH_W-1:0];
          default: ;
        endcase
      end
      if (pix.valid && pix.ready)
        pending_motion.push_back(predict_motion(pix.blue, pix.green, pix.red, pix.frame_start));
      if (res.valid && res.ready) begin
        if (pending_motion.size() == 0) begin
          $error("result with no pixel pending: gray %0d", res.gray);
          error_count++;
        end else begin
          want = pending_motion.pop_front();
          check_field("gray", 32'(want.gray), 32'(res.gray));
          check_field("foreground", 32'(want.foreground), 32'(res.foreground));
          check_field("is_spot", 32'(want.is_spot), 32'(res.is_spot));
          check_field("spot_motion", 32'(want.spot_motion), 32'(res.spot_motion));
          check_field("spot_row", 32'(want.spot_row), 32'(res.spot_row));
          check_field("spot_col", 32'(want.spot_col), 32'(res.spot_col));
          check_field("end_of_frame", 32'(want.end_of_frame), 32'(res.end_of_frame));
        end
      end
    end
  end

  // result side backpressure in bursts
  always @(posedge clk) begin
    if (sink_stall != 0) begin
      sink_stall--;
      res.ready <= 1'b0;
    end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
      sink_stall = $urandom_range(1, 11) - 1;
      res.ready <= 1'b0;
    end else begin
      res.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // leaves valid high; the caller lowers it once the last write is done
  task automatic write_reg(input logic [fdsm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fdsm_pkg::CFG_DATA_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= data;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
  endtask

  task automatic set_config(input logic [fdsm_pkg::CFG_DATA_W-1:0] w,
                            input logic [fdsm_pkg::CFG_DATA_W-1:0] h,
                            input logic [fdsm_pkg::CFG_DATA_W-1:0] t,
                            input logic [fdsm_pkg::CFG_DATA_W-1:0] p);
    write_reg(fdsm_pkg::REG_FRAME_WIDTH, w);
    write_reg(fdsm_pkg::REG_FRAME_HEIGHT, h);
    write_reg(fdsm_pkg::REG_DIFF_THRESHOLD, t);
    write_reg(fdsm_pkg::REG_SPOT_PITCH, p);
    cfg.valid <= 1'b0;
  endtask

  task automatic send_pixel(input logic [fdsm_pkg::PIX_W-1:0] b,
                            input logic [fdsm_pkg::PIX_W-1:0] g,
                            input logic [fdsm_pkg::PIX_W-1:0] r, input logic fs);
    int gap;
    if (src_idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 11);
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix.valid <= 1'b1;
    pix.blue <= b;
    pix.green <= g;
    pix.red <= r;
    pix.frame_start <= fs;
    @(posedge clk);
    while (!pix.ready) @(posedge clk);
  endtask

  task automatic hold_until_drained();
    pix.valid <= 1'b0;
    @(posedge clk);
    while (pending_motion.size() != 0) @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
    send_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
    send_pixel(8'h00, 8'h00, 8'hFF, 1'b0);
  endtask

  // one whole 3x2 frame and the first pixel of the next
  task automatic test_small_frame();
    int i;
    hold_until_drained();
    set_config(11'd3, 11'd2, 11'd0, 11'd2);
    for (i = 0; i < 7; i++)
      send_pixel(fdsm_pkg::PIX_W'(i * 40), fdsm_pkg::PIX_W'(255 - i * 40),
                 fdsm_pkg::PIX_W'(i * 7), i == 0);
  endtask

  // zero sizes and pitch act as one, threshold set to its maximum, stray index ignored
  task automatic test_degenerate_sizes();
    hold_until_drained();
    write_reg(fdsm_pkg::REG_FRAME_WIDTH, '0);
    write_reg(fdsm_pkg::REG_FRAME_HEIGHT, '0);
    write_reg(fdsm_pkg::REG_DIFF_THRESHOLD, '1);
    write_reg(fdsm_pkg::REG_SPOT_PITCH, '0);
    write_reg(REG_UNUSED, '1);
    cfg.valid <= 1'b0;
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
  endtask

  // oversized frame clamps, then shrinking it ends the row and then the frame
  task automatic test_size_change();
    int i;
    hold_until_drained();
    set_config(11'h7FF, 11'd1023, 11'd10, 11'd1);
    for (i = 0; i < 3; i++) send_pixel(8'h20, 8'h90, 8'h40, i == 0);
    hold_until_drained();
    set_config(11'd2, 11'd1023, 11'd10, 11'd1);
    send_pixel(8'h55, 8'h55, 8'h55, 1'b0);
    hold_until_drained();
    set_config(11'd2, 11'd1, 11'd10, 11'd1);
    send_pixel(8'hAA, 8'h10, 8'h70, 1'b0);
    send_pixel(8'h01, 8'hFE, 8'h80, 1'b0);
  endtask

  // pitch drops below the running column phase, then a mid-row frame start
  task automatic test_pitch_change();
    int i;
    hold_until_drained();
    set_config(11'd16, 11'd4, 11'd20, 11'd8);
    for (i = 0; i < 4; i++) send_pixel(fdsm_pkg::PIX_W'(i * 60), 8'h33, 8'hC0, i == 0);
    hold_until_drained();
    set_config(11'd16, 11'd4, 11'd20, 11'd3);
    send_pixel(8'h10, 8'h20, 8'h30, 1'b0);
    send_pixel(8'hF0, 8'hE0, 8'hD0, 1'b0);
    send_pixel(8'h80, 8'h80, 8'h80, 1'b1);
  endtask

  // frames of a slowly varying scene, with random pixels and stray frame starts mixed in
  task automatic run_random_phase(input int items);
    int unsigned w, h, t, p, frame_len, in_frame, scene, amp, base;
    int          sent;
    logic        fs;
    hold_until_drained();
    case ($urandom_range(0, 5))
      0: begin
        w = $urandom_range(0, 2047);
        h = $urandom_range(0, 1023);
      end
      1: begin
        w = $urandom_range(0, 1);
        h = 1023;
      end
      2: begin
        w = ($urandom_range(0, 1) != 0) ? 2047 : 1024;
        h = $urandom_range(1, 3);
      end
      default: begin
        w = $urandom_range(1, 12);
        h = $urandom_range(1, 6);
      end
    endcase
    case ($urandom_range(0, 4))
      0: t = 0;
      1: t = 255;
      2: t = $urandom_range(0, 2047);
      default: t = $urandom_range(0, 40);
    endcase
    case ($urandom_range(0, 5))
      0: p = 0;
      1: p = 1;
      2: p = 255;
      3: p = $urandom_range(0, 2047);
      default: p = $urandom_range(2, 5);
    endcase
    set_config(fdsm_pkg::CFG_DATA_W'(w), fdsm_pkg::CFG_DATA_W'(h),
               fdsm_pkg::CFG_DATA_W'(t), fdsm_pkg::CFG_DATA_W'(p));
    frame_len = clamp_to(w, fdsm_pkg::MAX_WIDTH_DEF) * clamp_to(h, fdsm_pkg::MAX_HEIGHT_DEF);
    scene = $urandom_range(0, 255);
    amp = $urandom_range(0, 40);
    in_frame = 0;
    for (sent = 0; sent < items; sent++) begin
      if (in_frame == 0) fs = $urandom_range(0, 9) != 0;
      else fs = $urandom_range(0, 39) == 0;
      if (fs) in_frame = 0;
      base = (in_frame * 53 + scene) & 8'hFF;
      if ($urandom_range(0, 3) == 0)
        send_pixel(fdsm_pkg::PIX_W'($urandom), fdsm_pkg::PIX_W'($urandom),
                   fdsm_pkg::PIX_W'($urandom), fs);
      else
        send_pixel(sat8(base + $urandom_range(0, amp)), sat8(base + $urandom_range(0, amp)),
                   sat8(base + $urandom_range(0, amp)), fs);
      in_frame = (in_frame + 1 >= frame_len) ? 0 : in_frame + 1;
      if (src_idle_on && $urandom_range(0, 49) == 0) hold_until_drained();
    end
  endtask

  task automatic test_random_frames();
    int phase;
    for (phase = 0; phase < 8; phase++) begin
      src_idle_on = $urandom_range(0, 3) != 0;
      sink_idle_on = $urandom_range(0, 3) != 0;
      run_random_phase(60);
    end
  endtask

  task automatic test_steady_stream();
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    run_random_phase(60);
  endtask

  initial begin
    rst = 1'b1;
    pix.valid = 1'b0;
    pix.blue = '0;
    pix.green = '0;
    pix.red = '0;
    pix.frame_start = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    res.ready = 1'b0;
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // the first pixel also waits out the frame store clear
    test_reset_defaults();
    test_small_frame();
    test_degenerate_sizes();
    test_size_change();
    test_pitch_change();
    test_random_frames();
    test_steady_stream();

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
